// ===== rtl/fpmu_pkg.sv =====
package fpmu_pkg;

   localparam int TOTAL_PAGES     = 4096;
   localparam int PAGES_PER_BLOCK = 64;
   localparam int NUM_BLOCKS      = TOTAL_PAGES / PAGES_PER_BLOCK;
   localparam int PAGE_W          = $clog2(TOTAL_PAGES);
   localparam int OFS_W           = $clog2(PAGES_PER_BLOCK);
   localparam int BLK_W           = PAGE_W - OFS_W;
   localparam int CNT_W           = 7;
   localparam int NFP_W           = OFS_W + 1;

   localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;
   localparam logic [NFP_W-1:0] NFP_FULL  = NFP_W'(PAGES_PER_BLOCK);

   typedef enum logic [1:0] {
      KIND_UPDATE = 2'd0,
      KIND_ALLOC  = 2'd1,
      KIND_RESET  = 2'd2,
      KIND_BAD    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_TWICE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FWD,
      ST_BLK
   } state_type;

   // forward map entry: valid mark and physical page
   typedef struct packed {
      logic              vld;
      logic [PAGE_W-1:0] page;
   } fwd_entry_type;

   // per-block row: invalid bitmap, invalid count, next free page
   typedef struct packed {
      logic [PAGES_PER_BLOCK-1:0] bits;
      logic [CNT_W-1:0]           cnt;
      logic [NFP_W-1:0]           nfp;
   } blk_row_type;

endpackage

// ===== rtl/fpmu_fwd_mem.sv =====
module fpmu_fwd_mem
   import fpmu_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [PAGE_W-1:0] rd_addr,
   output fwd_entry_type     rd_data,
   input  logic              wr_en,
   input  logic [PAGE_W-1:0] wr_addr,
   input  fwd_entry_type     wr_data
);

   fwd_entry_type mem [TOTAL_PAGES];
   fwd_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fpmu_blk_mem.sv =====
module fpmu_blk_mem
   import fpmu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [BLK_W-1:0] rd_addr,
   output blk_row_type      rd_data,
   input  logic             wr_en,
   input  logic [BLK_W-1:0] wr_addr,
   input  blk_row_type      wr_data
);

   blk_row_type            mem [NUM_BLOCKS];
   blk_row_type            rd_data_ff;
   logic                   rd_vld_ff;
   logic [NUM_BLOCKS-1:0]  row_vld_ff;

   // a row never written since reset reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= row_vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/flash_page_map_update_unit.sv =====
// Page map engine of a flash translation layer. Holds the forward
// logical-to-physical map in a 4096-entry RAM and one row per block (invalid
// bitmap, invalid count, next free page) in a 64-row RAM. After reset the
// forward map is swept clear, one entry per cycle; req_tready stays low until
// then. A map update then passes through a forward map read, a block row read
// and a write back; block allocate, block reset and an invalid kind skip the
// forward map read. The write back waits while an earlier result still sits on
// rsp. The next item is taken while a result waits on rsp.
module flash_page_map_update_unit
   import fpmu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // logical_page[11:0], physical_page[23:12], block_index[29:24]
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // old_valid[0], old_physical_page[12:1],
                                    // allocated_page[24:13], invalid_count[31:25]
   output logic [1:0]  rsp_tuser    // status
);

   state_type           state_ff, state_in;
   logic [PAGE_W:0]     clr_cnt_ff, clr_cnt_in;
   kind_type            kind_ff;
   logic [PAGE_W-1:0]   lp_ff, pp_ff;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic                accept;
   logic                out_free;
   logic                finish;

   logic                fwd_rd_en, fwd_wr_en;
   logic [PAGE_W-1:0]   fwd_wr_addr;
   fwd_entry_type       fwd_q, fwd_wr_data;
   logic                blk_rd_en, blk_wr_en;
   logic [BLK_W-1:0]    blk_rd_addr;
   blk_row_type         blk_q, blk_new;

   logic                rsp_vld_ff, rsp_vld_in;
   status_type          st_ff, st_in;
   logic                ov_ff, ov_in;
   logic [PAGE_W-1:0]   op_ff, op_in, ap_ff, ap_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign finish   = (state_ff == ST_BLK) && out_free;

   fpmu_fwd_mem u_fwd (
      .clock  (clock),
      .rd_en  (fwd_rd_en),
      .rd_addr(req_tdata[PAGE_W-1:0]),
      .rd_data(fwd_q),
      .wr_en  (fwd_wr_en),
      .wr_addr(fwd_wr_addr),
      .wr_data(fwd_wr_data)
   );

   fpmu_blk_mem u_blk (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (blk_rd_en),
      .rd_addr(blk_rd_addr),
      .rd_data(blk_q),
      .wr_en  (blk_wr_en),
      .wr_addr(blk_ff),
      .wr_data(blk_new)
   );

   // next state
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (PAGE_W+1)'(TOTAL_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (kind_type'(req_tuser) == KIND_UPDATE) ? ST_FWD : ST_BLK;
            end
         end
         ST_FWD: state_in = ST_BLK;
         ST_BLK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // block of the item: block_index on accept; for a map update, old page if mapped, else new page
   always_comb begin
      blk_in = blk_ff;
      if (accept) begin
         blk_in = req_tdata[2*PAGE_W +: BLK_W];
      end else if (state_ff == ST_FWD) begin
         blk_in = fwd_q.vld ? fwd_q.page[PAGE_W-1 -: BLK_W] : pp_ff[PAGE_W-1 -: BLK_W];
      end
   end

   // outputs of the sequencer
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      fwd_rd_en   = accept;
      blk_rd_en   = accept || (state_ff == ST_FWD);
      blk_rd_addr = blk_in;
      fwd_wr_en   = 1'b0;
      fwd_wr_addr = clr_cnt_ff[PAGE_W-1:0];
      fwd_wr_data = '0;
      blk_wr_en   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: fwd_wr_en = 1'b1;
         ST_BLK: begin
            blk_wr_en = finish && (kind_ff != KIND_BAD);
            if (kind_ff == KIND_UPDATE) begin
               fwd_wr_en        = finish;
               fwd_wr_addr      = lp_ff;
               fwd_wr_data.vld  = 1'b1;
               fwd_wr_data.page = pp_ff;
            end
         end
         default: ;
      endcase
   end

   // row update and result
   always_comb begin
      blk_new = blk_q;
      st_in   = STATUS_OK;
      ov_in   = 1'b0;
      op_in   = '0;
      ap_in   = '0;
      cnt_in  = '0;
      unique case (kind_ff)
         KIND_UPDATE: begin
            if (fwd_q.vld) begin
               ov_in = 1'b1;
               op_in = fwd_q.page;
               if (blk_q.bits[fwd_q.page[OFS_W-1:0]]) begin
                  st_in = STATUS_TWICE;
               end
               blk_new.bits[fwd_q.page[OFS_W-1:0]] = 1'b1;
               if (blk_q.cnt != COUNT_MAX) begin
                  blk_new.cnt = blk_q.cnt + 1'b1;
               end
            end
            cnt_in = blk_new.cnt;
         end
         KIND_ALLOC: begin
            cnt_in = blk_q.cnt;
            if (blk_q.nfp >= NFP_FULL) begin
               st_in = STATUS_FULL;
            end else begin
               blk_new.nfp = blk_q.nfp + 1'b1;
               ap_in       = {blk_ff, blk_q.nfp[OFS_W-1:0]};
            end
         end
         KIND_RESET: blk_new = '0;
         KIND_BAD:   st_in   = STATUS_RANGE;
         default:    st_in   = STATUS_RANGE;
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (finish) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (accept) begin
         kind_ff <= kind_type'(req_tuser);
         lp_ff   <= req_tdata[PAGE_W-1:0];
         pp_ff   <= req_tdata[PAGE_W +: PAGE_W];
      end
      if (finish) begin
         st_ff  <= st_in;
         ov_ff  <= ov_in;
         op_ff  <= op_in;
         ap_ff  <= ap_in;
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = st_ff;
   assign rsp_tdata  = {cnt_ff, ap_ff, op_ff, ov_ff};

endmodule

// ===== tb/tb_flash_page_map_update_unit.sv =====
`timescale 1ns / 1ps

module tb_flash_page_map_update_unit;
   import fpmu_pkg::*;

   typedef struct packed {
      status_type       status;
      logic             old_valid;
      logic [11:0]      old_page;
      logic [11:0]      alloc_page;
      logic [CNT_W-1:0] inv_count;
   } page_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   flash_page_map_update_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [11:0]          fwd_page [TOTAL_PAGES];
   logic                 fwd_vld  [TOTAL_PAGES];
   logic [63:0]          inv_bits [NUM_BLOCKS];
   logic [CNT_W-1:0]     inv_cnt  [NUM_BLOCKS];
   logic [NFP_W-1:0]     next_free[NUM_BLOCKS];

   page_result_type pending_results[$];
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit stall_enable = 1;
   localparam int WATCHDOG = 20000;

   function automatic page_result_type predict_page_map(kind_type k, logic [11:0] lp,
                                                        logic [11:0] pp, logic [5:0] blk);
      page_result_type r;
      int unsigned aff;
      r = '0;
      r.status = STATUS_OK;
      case (k)
         KIND_UPDATE: begin
            if (fwd_vld[lp]) begin
               r.old_valid = 1'b1;
               r.old_page  = fwd_page[lp];
               aff = fwd_page[lp] / PAGES_PER_BLOCK;
               if (inv_bits[aff][fwd_page[lp] % PAGES_PER_BLOCK]) r.status = STATUS_TWICE;
               inv_bits[aff][fwd_page[lp] % PAGES_PER_BLOCK] = 1'b1;
               if (inv_cnt[aff] < COUNT_MAX) inv_cnt[aff] = inv_cnt[aff] + 1'b1;
            end else begin
               aff = pp / PAGES_PER_BLOCK;
            end
            fwd_page[lp] = pp;
            fwd_vld[lp]  = 1'b1;
            r.inv_count  = inv_cnt[aff];
         end
         KIND_ALLOC: begin
            r.inv_count = inv_cnt[blk];
            if (next_free[blk] >= NFP_FULL) begin
               r.status = STATUS_FULL;
            end else begin
               r.alloc_page = 12'(blk * PAGES_PER_BLOCK + next_free[blk]);
               next_free[blk] = next_free[blk] + 1'b1;
            end
         end
         KIND_RESET: begin
            inv_bits[blk]  = '0;
            inv_cnt[blk]   = '0;
            next_free[blk] = '0;
         end
         default: r.status = STATUS_RANGE;
      endcase
      return r;
   endfunction

   task automatic send_item(kind_type k, logic [11:0] lp, logic [11:0] pp, logic [5:0] blk);
      pending_results.push_back(predict_page_map(k, lp, pp, blk));
      req_tdata  <= {2'b00, blk, pp, lp};
      req_tuser  <= k;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
   endtask

   task automatic idle_gap(int n);
      drop_valid();
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (!stall_enable) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 9) < 6);
   end

   // result checker
   always @(posedge clock) begin
      page_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status     = status_type'(rsp_tuser);
         got.old_valid  = rsp_tdata[0];
         got.old_page   = rsp_tdata[12:1];
         got.alloc_page = rsp_tdata[24:13];
         got.inv_count  = rsp_tdata[31:25];
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at result %0d: expected %p got %p",
                           results_seen, want, got);
            end
         end
      end
   end

   // watchdog: the reset sweep is allowed for in the limit
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(KIND_UPDATE, 12'd0, 12'd0, 6'd0);
      send_item(KIND_UPDATE, 12'd0, 12'd0, 6'd0);       // remap to own page
      send_item(KIND_UPDATE, 12'd0, 12'd4095, 6'd63);
      send_item(KIND_UPDATE, 12'd4095, 12'd0, 6'd63);   // page 0 already invalid
      send_item(KIND_UPDATE, 12'd0, 12'd100, 6'd0);
      send_item(KIND_ALLOC, 12'hfff, 12'hfff, 6'd0);
      send_item(KIND_ALLOC, 12'd0, 12'd0, 6'd63);
      send_item(KIND_RESET, 12'd0, 12'd0, 6'd0);
      send_item(KIND_RESET, 12'hfff, 12'hfff, 6'd63);
      send_item(KIND_BAD, 12'hfff, 12'hfff, 6'h3f);
      send_item(KIND_BAD, 12'd0, 12'd0, 6'd0);
      // fill block 5 then hit it full
      repeat (65) send_item(KIND_ALLOC, 12'd0, 12'd0, 6'd5);
      send_item(KIND_RESET, 12'd0, 12'd0, 6'd5);
      send_item(KIND_ALLOC, 12'd0, 12'd0, 6'd5);
      wait_drained();
   endtask

   task automatic test_saturation();
      // remap one logical page many times within block 7 to saturate count
      repeat (140) send_item(KIND_UPDATE, 12'd77, 12'(7 * 64 + $urandom_range(0, 63)), 6'd0);
      send_item(KIND_ALLOC, 12'd0, 12'd0, 6'd7);
      send_item(KIND_RESET, 12'd0, 12'd0, 6'd7);
      wait_drained();
   endtask

   task automatic test_random(int n);
      int burst;
      logic [11:0] lp, pp;
      kind_type k;
      int sel;
      while (n > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && n > 0) begin
            sel = $urandom_range(0, 99);
            // small logical pool so remaps happen often
            lp = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
            pp = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 255));
            if (sel < 55) k = KIND_UPDATE;
            else if (sel < 85) k = KIND_ALLOC;
            else if (sel < 95) k = KIND_RESET;
            else k = KIND_BAD;
            send_item(k, lp, pp, ($urandom_range(0, 1)) ? 6'($urandom) : 6'($urandom_range(0, 3)));
            burst--;
            n--;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < TOTAL_PAGES; i++) begin
         fwd_page[i] = '0;
         fwd_vld[i]  = 1'b0;
      end
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         inv_bits[b] = '0; inv_cnt[b] = '0; next_free[b] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_saturation();
      stall_enable = 0;
      test_random(150);
      stall_enable = 1;
      test_random(500);
      $display("sent %0d items, checked %0d results: map updates, remaps, allocation,",
               items_sent, results_seen);
      $display("block full, block reset, bad kinds and count saturation");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches,
                  pending_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/fpmu_pkg.sv
rtl/fpmu_fwd_mem.sv
rtl/fpmu_blk_mem.sv
rtl/flash_page_map_update_unit.sv
tb/tb_flash_page_map_update_unit.sv
